@@ rtl/acr_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the
// associative cache replacement block. No dependencies.
package acr_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BITS  = 32;
  localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  localparam int IN_KEY_BITS    = 32;
  localparam int COUNT_BITS     = 32;
  localparam int POLICY_BITS    = 2;
  localparam int SIZE_BITS      = 5;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 5;

  typedef logic [KEY_BITS-1:0] key_t;

  // replacement policy codes; the unused code behaves as FIFO
  localparam logic [POLICY_BITS-1:0] POL_FIFO  = 2'd0;
  localparam logic [POLICY_BITS-1:0] POL_LRU   = 2'd1;
  localparam logic [POLICY_BITS-1:0] POL_CLOCK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_HIT        = 2'd0;
  localparam logic [1:0] KIND_COMPULSORY = 2'd1;
  localparam logic [1:0] KIND_CAPACITY   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE   = 2'd1;

  localparam logic [POLICY_BITS-1:0] POLICY_RESET = POL_FIFO;
  localparam logic [SIZE_BITS-1:0]   SIZE_RESET   = 5'd16;

  typedef struct packed {
    logic load;    // latch key, clamp pointers, restart scan
    logic scan;    // examine one entry
    logic sweep;   // examine reference bit under the hand
    logic commit;  // apply the update and register the result
  } ctl_cmd_t;

  typedef struct packed {
    logic match;      // entry under scan index holds the key
    logic last;       // scan index is the last entry in use
    logic full;       // no free slot left
    logic pol_clock;  // clock policy selected
    logic ref_clear;  // reference bit under the hand is clear
  } ctl_status_t;

  // fit the 32-bit input key to the stored key width
  function automatic key_t to_key(logic [IN_KEY_BITS-1:0] k);
    key_t r;
    r = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (i < IN_KEY_BITS) begin
        r[i] = k[i];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/acr_ctrl.sv @@
// Sequencer for the associative cache replacement block: scan, clock sweep,
// commit. Uses acr_pkg for command and status types.
module acr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  acr_pkg::ctl_status_t status,
  output acr_pkg::ctl_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.match) begin
          state_next = S_COMMIT;
        end else if (status.last) begin
          state_next = (status.full && status.pol_clock) ? S_SWEEP : S_COMMIT;
        end
      end
      S_SWEEP: begin
        if (status.ref_clear) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.sweep  = (state == S_SWEEP);
  assign cmd.commit = (state == S_COMMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_COMMIT);
    end
  end

  // a result strobe is never asserted back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  // every commit step is followed by a result strobe with busy low
  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done && !busy)
    else $error("commit not followed by result strobe");

endmodule

@@ rtl/acr_datapath.sv @@
// Entry store, replacement state, configuration registers and miss totals.
// Driven by acr_ctrl through acr_pkg command and status types.
module acr_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  acr_pkg::ctl_cmd_t                    cmd,
  output acr_pkg::ctl_status_t                 status,
  input  logic [acr_pkg::IN_KEY_BITS-1:0]      access_key,
  input  logic                                 cfg_we,
  input  logic [acr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [acr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                 hit,
  output logic [1:0]                           miss_kind,
  output logic [acr_pkg::COUNT_BITS-1:0]       compulsory_count,
  output logic [acr_pkg::COUNT_BITS-1:0]       capacity_count
);

  localparam int CAP = acr_pkg::CAPACITY;
  localparam int IW  = acr_pkg::IDX_BITS;
  localparam int CW  = acr_pkg::CNT_BITS;

  acr_pkg::key_t keys [CAP];
  logic [CAP-1:0] valid;
  logic [CAP-1:0] refb;
  logic [IW-1:0]  rank [CAP];

  logic [IW-1:0] ptr;
  logic [IW-1:0] hand;
  logic [CW-1:0] occ;
  logic [acr_pkg::COUNT_BITS-1:0] comp_total;
  logic [acr_pkg::COUNT_BITS-1:0] cap_total;

  logic [acr_pkg::POLICY_BITS-1:0] policy;
  logic [acr_pkg::SIZE_BITS-1:0]   cfg_size;

  acr_pkg::key_t key_reg;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] victim;
  logic [IW-1:0] victim_rank;
  logic          found;

  logic [CW-1:0] s_use;
  logic          pol_lru;
  logic          pol_clock;
  logic          full;
  logic [IW-1:0] rank_cur;
  logic [IW-1:0] hand_inc;
  logic [IW-1:0] ptr_inc;
  logic [IW-1:0] slot_w;
  logic [CAP-1:0] age_en;
  logic          cfg_flush;

  always_comb begin
    if (cfg_size == '0) begin
      s_use = CW'(1);
    end else if (32'(cfg_size) > CAP) begin
      s_use = CW'(CAP);
    end else begin
      s_use = CW'(cfg_size);
    end
  end

  assign pol_lru   = (policy == acr_pkg::POL_LRU);
  assign pol_clock = (policy == acr_pkg::POL_CLOCK);
  assign full      = (occ >= s_use);
  assign rank_cur  = rank[scan_idx];
  assign hand_inc  = ((CW'(hand) + CW'(1)) == s_use) ? '0 : hand + IW'(1);
  assign ptr_inc   = ((CW'(ptr) + CW'(1)) == s_use) ? '0 : ptr + IW'(1);
  assign cfg_flush = cfg_we && (cfg_index == acr_pkg::REG_POLICY ||
                                cfg_index == acr_pkg::REG_SIZE);

  assign status.match     = valid[scan_idx] && (keys[scan_idx] == key_reg);
  assign status.last      = ((CW'(scan_idx) + CW'(1)) == s_use);
  assign status.full      = full;
  assign status.pol_clock = pol_clock;
  assign status.ref_clear = !refb[hand];

  // slot touched by the commit
  always_comb begin
    priority if (found) begin
      slot_w = scan_idx;
    end else if (!full) begin
      slot_w = occ[IW-1:0];
    end else if (pol_lru) begin
      slot_w = victim;
    end else if (pol_clock) begin
      slot_w = hand;
    end else begin
      slot_w = ptr;
    end
  end

  // on a hit age only the entries more recent than the hit one
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      age_en[i] = cmd.commit && pol_lru && valid[i] && (IW'(i) != slot_w) &&
                  (!found || (rank[i] < rank_cur));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= acr_pkg::POLICY_RESET;
      cfg_size   <= acr_pkg::SIZE_RESET;
      valid      <= '0;
      refb       <= '0;
      ptr        <= '0;
      hand       <= '0;
      occ        <= '0;
      comp_total <= '0;
      cap_total  <= '0;
      for (int i = 0; i < CAP; i++) begin
        rank[i] <= '0;
      end
    end else if (cfg_flush) begin
      if (cfg_index == acr_pkg::REG_POLICY) begin
        policy <= cfg_data[acr_pkg::POLICY_BITS-1:0];
      end else begin
        cfg_size <= cfg_data[acr_pkg::SIZE_BITS-1:0];
      end
      valid <= '0;
      refb  <= '0;
      ptr   <= '0;
      hand  <= '0;
      occ   <= '0;
      for (int i = 0; i < CAP; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.load) begin
      if (occ > s_use) begin
        occ <= s_use;
      end
      if (CW'(ptr) >= s_use) begin
        ptr <= '0;
      end
      if (CW'(hand) >= s_use) begin
        hand <= '0;
      end
    end else if (cmd.sweep) begin
      // second chance: clear and pass over referenced entries
      if (refb[hand]) begin
        refb[hand] <= 1'b0;
        hand       <= hand_inc;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < CAP; i++) begin
        if (age_en[i]) begin
          rank[i] <= rank[i] + IW'(1);
        end
      end
      if (found) begin
        if (pol_lru) begin
          rank[slot_w] <= '0;
        end
        if (pol_clock) begin
          refb[slot_w] <= 1'b1;
        end
      end else if (!full) begin
        valid[slot_w] <= 1'b1;
        rank[slot_w]  <= '0;
        refb[slot_w]  <= 1'b1;
        occ           <= occ + CW'(1);
        if (comp_total != '1) begin
          comp_total <= comp_total + 1'b1;
        end
      end else begin
        valid[slot_w] <= 1'b1;
        if (pol_lru) begin
          rank[slot_w] <= '0;
        end else if (pol_clock) begin
          refb[slot_w] <= 1'b1;
          hand         <= hand_inc;
        end else begin
          ptr <= ptr_inc;
        end
        if (cap_total != '1) begin
          cap_total <= cap_total + 1'b1;
        end
      end
    end
  end

  // key store, scan registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg     <= acr_pkg::to_key(access_key);
      scan_idx    <= '0;
      victim      <= '0;
      victim_rank <= rank[0];
      found       <= 1'b0;
    end else if (cmd.scan) begin
      if (status.match) begin
        found <= 1'b1;
      end else begin
        // track the oldest entry; ties go to the later slot
        if (rank_cur >= victim_rank) begin
          victim      <= scan_idx;
          victim_rank <= rank_cur;
        end
        if (!status.last) begin
          scan_idx <= scan_idx + IW'(1);
        end
      end
    end
    if (cmd.commit) begin
      hit <= found;
      if (found) begin
        miss_kind <= acr_pkg::KIND_HIT;
      end else if (!full) begin
        miss_kind <= acr_pkg::KIND_COMPULSORY;
      end else begin
        miss_kind <= acr_pkg::KIND_CAPACITY;
      end
      if (!found) begin
        keys[slot_w] <= key_reg;
      end
    end
  end

  assign compulsory_count = comp_total;
  assign capacity_count   = cap_total;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> occ <= s_use)
    else $error("occupancy exceeds size in use");

  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (hit == (miss_kind == acr_pkg::KIND_HIT)))
    else $error("hit flag disagrees with miss kind");

  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(comp_total) && $stable(cap_total))
    else $error("miss totals moved outside a commit");

  a_sweep_stops: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep && !refb[hand] |=> cmd.commit)
    else $error("clock sweep did not stop at a clear reference bit");

endmodule

@@ rtl/assoc_cache_replacement.sv @@
// Fully associative cache replacement block: an item is one access key, the
// result is hit/miss kind plus saturating compulsory and capacity miss totals.
// Depends on acr_pkg, acr_ctrl and acr_datapath.
//
// Pulse start while busy is low to hand in access_key. The lookup scan checks
// one entry per cycle through a single key comparator and stops at a match or
// at the last entry in use; on a clock-policy capacity miss the second-chance
// sweep then checks one reference bit per cycle until it finds a clear one.
// The result is on the output ports for exactly one cycle, marked by done, and
// must be taken then: the receiver cannot stall. A new start may be given in
// the done cycle. Configuration writes to the policy or size register
// (cfg_valid with cfg_ready, taken while busy is low) empty the cache but keep
// the miss totals; reset needs no clearing pass.
module assoc_cache_replacement (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [acr_pkg::IN_KEY_BITS-1:0]      access_key,
  output logic                                 done,
  output logic                                 hit,
  output logic [1:0]                           miss_kind,
  output logic [acr_pkg::COUNT_BITS-1:0]       compulsory_count,
  output logic [acr_pkg::COUNT_BITS-1:0]       capacity_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [acr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [acr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  acr_pkg::ctl_cmd_t    cmd;
  acr_pkg::ctl_status_t status;
  logic                 cfg_we;
  logic                 start_ok;

  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign start_ok  = start && !busy;

  acr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start_ok),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  acr_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .access_key       (access_key),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .hit              (hit),
    .miss_kind        (miss_kind),
    .compulsory_count (compulsory_count),
    .capacity_count   (capacity_count)
  );

endmodule

@@ bench/tb_assoc_cache_replacement.sv @@
// Self-checking bench for assoc_cache_replacement: access keys and register writes
// against a shadow cache kept here, covering FIFO, LRU and clock replacement.
// Depends on acr_pkg and the assoc_cache_replacement RTL.
`timescale 1ns / 1ps

module tb_assoc_cache_replacement;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 30;
  localparam int RANDOM_ACCESSES = 600;
  localparam int DATA_W = acr_pkg::CFG_DATA_BITS;
  localparam int SIZE_W = acr_pkg::SIZE_BITS;
  localparam int CNT_W  = acr_pkg::COUNT_BITS;
  localparam logic [acr_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [acr_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_B = 2'd3;

  typedef enum logic [1:0] {ACT_ACCESS, ACT_WRITE, ACT_DRAIN} act_kind_t;

  typedef struct packed {
    act_kind_t                         kind;
    logic [acr_pkg::IN_KEY_BITS-1:0]   key;
    logic [acr_pkg::CFG_IDX_BITS-1:0]  idx;
    logic [acr_pkg::CFG_DATA_BITS-1:0] data;
  } plan_step_t;

  typedef struct packed {
    logic                           hit;
    logic [1:0]                     kind;
    logic [acr_pkg::COUNT_BITS-1:0] compulsory;
    logic [acr_pkg::COUNT_BITS-1:0] capacity;
  } outcome_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic [acr_pkg::IN_KEY_BITS-1:0]   access_key = '0;
  logic                              done;
  logic                              hit;
  logic [1:0]                        miss_kind;
  logic [acr_pkg::COUNT_BITS-1:0]    compulsory_count;
  logic [acr_pkg::COUNT_BITS-1:0]    capacity_count;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [acr_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [acr_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  assoc_cache_replacement i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .access_key       (access_key),
    .done             (done),
    .hit              (hit),
    .miss_kind        (miss_kind),
    .compulsory_count (compulsory_count),
    .capacity_count   (capacity_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  plan_step_t access_plan[$];
  outcome_t   expected_outcomes[$];

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned gap_left;
  int unsigned cycle_cnt;
  bit          presenting;

  // shadow copy of the cache
  logic [acr_pkg::POLICY_BITS-1:0] shadow_policy;
  logic [acr_pkg::SIZE_BITS-1:0]   shadow_size;
  logic [acr_pkg::IN_KEY_BITS-1:0] shadow_keys [acr_pkg::CAPACITY];
  bit                              shadow_valid [acr_pkg::CAPACITY];
  bit                              shadow_ref [acr_pkg::CAPACITY];
  int unsigned                     shadow_rank [acr_pkg::CAPACITY];
  int unsigned                     shadow_fifo_ptr;
  int unsigned                     shadow_hand;
  int unsigned                     shadow_fill;
  logic [acr_pkg::COUNT_BITS-1:0]  compulsory_tot;
  logic [acr_pkg::COUNT_BITS-1:0]  capacity_tot;

  function automatic void empty_shadow();
    for (int i = 0; i < acr_pkg::CAPACITY; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_ref[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_fifo_ptr = 0;
    shadow_hand = 0;
    shadow_fill = 0;
  endfunction

  function automatic void write_register(logic [acr_pkg::CFG_IDX_BITS-1:0] idx,
                                         logic [acr_pkg::CFG_DATA_BITS-1:0] data);
    if (idx == acr_pkg::REG_POLICY) begin
      shadow_policy = data[acr_pkg::POLICY_BITS-1:0];
      empty_shadow();
    end else if (idx == acr_pkg::REG_SIZE) begin
      shadow_size = data;
      empty_shadow();
    end
  endfunction

  function automatic void age_recency(int unsigned limit, int unsigned skip);
    for (int i = 0; i < acr_pkg::CAPACITY; i++) begin
      if (shadow_valid[i] && i != skip && shadow_rank[i] < limit) begin
        shadow_rank[i]++;
      end
    end
  endfunction

  // look the key up, update the shadow cache and queue the expected outcome
  function automatic void lookup_and_replace(logic [acr_pkg::IN_KEY_BITS-1:0] key);
    int unsigned s;
    int unsigned slot;
    bit          found;
    bit          stop;
    outcome_t    o;
    s = (shadow_size == 0) ? 1 :
        ((shadow_size > acr_pkg::CAPACITY) ? acr_pkg::CAPACITY : shadow_size);
    if (shadow_fill > s) shadow_fill = s;
    if (shadow_fifo_ptr >= s) shadow_fifo_ptr = 0;
    if (shadow_hand >= s) shadow_hand = 0;
    found = 1'b0;
    slot = 0;
    for (int i = 0; i < s; i++) begin
      if (!found && shadow_valid[i] && shadow_keys[i] == key) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      o.kind = acr_pkg::KIND_HIT;
      if (shadow_policy == acr_pkg::POL_LRU) begin
        age_recency(shadow_rank[slot], slot);
        shadow_rank[slot] = 0;
      end else if (shadow_policy == acr_pkg::POL_CLOCK) begin
        shadow_ref[slot] = 1'b1;
      end
    end else if (shadow_fill < s) begin
      o.kind = acr_pkg::KIND_COMPULSORY;
      slot = shadow_fill;
      if (shadow_policy == acr_pkg::POL_LRU) age_recency(32'hFFFF, slot);
      shadow_keys[slot] = key;
      shadow_valid[slot] = 1'b1;
      shadow_rank[slot] = 0;
      shadow_ref[slot] = 1'b1;
      shadow_fill++;
      if (compulsory_tot != '1) compulsory_tot++;
    end else begin
      o.kind = acr_pkg::KIND_CAPACITY;
      if (shadow_policy == acr_pkg::POL_LRU) begin
        slot = 0;
        for (int i = 0; i < s; i++) begin
          if (shadow_rank[i] >= shadow_rank[slot]) slot = i;
        end
        age_recency(32'hFFFF, slot);
        shadow_rank[slot] = 0;
      end else if (shadow_policy == acr_pkg::POL_CLOCK) begin
        // second chance: clear set bits until a clear one is under the hand
        stop = 1'b0;
        for (int i = 0; i <= s; i++) begin
          if (!stop) begin
            if (!shadow_ref[shadow_hand]) begin
              stop = 1'b1;
            end else begin
              shadow_ref[shadow_hand] = 1'b0;
              shadow_hand = (shadow_hand + 1) % s;
            end
          end
        end
        slot = shadow_hand;
        shadow_ref[slot] = 1'b1;
        shadow_hand = (shadow_hand + 1) % s;
      end else begin
        slot = shadow_fifo_ptr;
        shadow_fifo_ptr = (shadow_fifo_ptr + 1) % s;
      end
      shadow_keys[slot] = key;
      shadow_valid[slot] = 1'b1;
      if (capacity_tot != '1) capacity_tot++;
    end
    o.hit = found;
    o.compulsory = compulsory_tot;
    o.capacity = capacity_tot;
    expected_outcomes.push_back(o);
  endfunction

  function automatic void plan_access(logic [acr_pkg::IN_KEY_BITS-1:0] key);
    plan_step_t p;
    p = '{kind: ACT_ACCESS, key: key, idx: '0, data: '0};
    access_plan.push_back(p);
  endfunction

  function automatic void plan_write(logic [acr_pkg::CFG_IDX_BITS-1:0] idx,
                                     logic [acr_pkg::CFG_DATA_BITS-1:0] data);
    plan_step_t p;
    p = '{kind: ACT_WRITE, key: '0, idx: idx, data: data};
    access_plan.push_back(p);
  endfunction

  function automatic void plan_drain();
    plan_step_t p;
    p = '{kind: ACT_DRAIN, key: '0, idx: '0, data: '0};
    access_plan.push_back(p);
  endfunction

  function automatic void note_mismatch(string what, logic [acr_pkg::COUNT_BITS-1:0] want,
                                        logic [acr_pkg::COUNT_BITS-1:0] got);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
    mismatches++;
  endfunction

  // driver: one plan step on the ports at a time
  always @(posedge clk) begin : driver
    logic       nxt_start;
    logic       nxt_cfg_valid;
    plan_step_t step;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      presenting = 1'b0;
      items_sent = 0;
      gap_left = 0;
      cycle_cnt = 0;
    end else begin
      cycle_cnt++;
      nxt_start = start;
      nxt_cfg_valid = cfg_valid;
      if (start && !busy) begin
        lookup_and_replace(access_key);
        items_sent++;
        nxt_start = 1'b0;
        presenting = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        write_register(cfg_index, cfg_data);
        nxt_cfg_valid = 1'b0;
        presenting = 1'b0;
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (!presenting && access_plan.size() != 0) begin
        step = access_plan[0];
        case (step.kind)
          ACT_ACCESS: begin
            // no idling in the middle stretch of the run
            if (!(cycle_cnt >= 5000 && cycle_cnt < 10000) && $urandom_range(99) < 21) begin
              gap_left = $urandom_range(1, 12);
            end else begin
              void'(access_plan.pop_front());
              access_key <= step.key;
              nxt_start = 1'b1;
              presenting = 1'b1;
            end
          end
          ACT_WRITE: begin
            // write only once the block is idle
            if (items_sent == results_seen && !busy) begin
              void'(access_plan.pop_front());
              cfg_index <= step.idx;
              cfg_data <= step.data;
              nxt_cfg_valid = 1'b1;
              presenting = 1'b1;
            end
          end
          default: begin
            if (items_sent == results_seen) void'(access_plan.pop_front());
          end
        endcase
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // monitor: compare each result with the oldest expected outcome
  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst) begin
      results_seen <= 0;
    end else if (done) begin
      results_seen <= results_seen + 1;
      if (expected_outcomes.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: result with nothing expected: hit %0b kind %0d", $time, hit,
                   miss_kind);
        end
        mismatches++;
      end else begin
        want = expected_outcomes.pop_front();
        if (hit !== want.hit) note_mismatch("hit", CNT_W'(want.hit), CNT_W'(hit));
        if (miss_kind !== want.kind) begin
          note_mismatch("miss_kind", CNT_W'(want.kind), CNT_W'(miss_kind));
        end
        if (compulsory_count !== want.compulsory) begin
          note_mismatch("compulsory_count", want.compulsory, compulsory_count);
        end
        if (capacity_count !== want.capacity) begin
          note_mismatch("capacity_count", want.capacity, capacity_count);
        end
      end
    end
  end

  // watchdog: count cycles in which nothing moves
  always @(posedge clk) begin : watchdog
    int unsigned stall;
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      stall = 0;
    end else begin
      stall++;
      if (stall >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : main
    logic [acr_pkg::IN_KEY_BITS-1:0] ka, kb, kc, kd;
    logic [acr_pkg::IN_KEY_BITS-1:0] pool[$];
    logic [acr_pkg::SIZE_BITS-1:0]   sz;
    int unsigned                     eff, n, r, random_cnt;

    mismatches = 0;
    shadow_policy = acr_pkg::POLICY_RESET;
    shadow_size = acr_pkg::SIZE_RESET;
    compulsory_tot = '0;
    capacity_tot = '0;
    empty_shadow();

    ka = 32'h1234_5678;
    kb = 32'hEDCB_A987;
    kc = 32'h5A5A_5A5A;
    kd = 32'hA5A5_A5A5;

    // reset setting: FIFO over all entries, key extremes
    plan_access('0);
    plan_access('1);
    plan_access('0);
    // FIFO with two entries: evictions in insert order
    plan_write(acr_pkg::REG_SIZE, 5'd2);
    plan_access(ka);
    plan_access(kb);
    plan_access(kc);
    plan_access(ka);
    plan_access(kc);
    // LRU: a hit protects the entry from eviction
    plan_write(acr_pkg::REG_POLICY, DATA_W'(acr_pkg::POL_LRU));
    plan_access(ka);
    plan_access(kb);
    plan_access(ka);
    plan_access(kc);
    plan_access(kb);
    // clock with three entries: full sweep on the first eviction
    plan_write(acr_pkg::REG_POLICY, DATA_W'(acr_pkg::POL_CLOCK));
    plan_write(acr_pkg::REG_SIZE, 5'd3);
    plan_access(ka);
    plan_access(kb);
    plan_access(kc);
    plan_access(ka);
    plan_access(kd);
    plan_access(ka);
    plan_drain();
    // spare policy code runs as FIFO; size zero holds one entry
    plan_write(acr_pkg::REG_POLICY, 5'd31);
    plan_write(acr_pkg::REG_SIZE, 5'd0);
    plan_access(ka);
    plan_access(kb);
    plan_access(kb);
    // oversize clamps to full capacity; unused indexes must not flush
    plan_write(acr_pkg::REG_SIZE, 5'd31);
    plan_access(ka);
    plan_write(REG_UNUSED_A, 5'd5);
    plan_write(REG_UNUSED_B, 5'd31);
    plan_access(ka);

    random_cnt = 0;
    while (random_cnt < RANDOM_ACCESSES) begin
      if ($urandom_range(5) == 0) begin
        plan_write($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B,
                   DATA_W'($urandom_range(31)));
      end
      r = $urandom_range(99);
      if (r < 70) sz = SIZE_W'($urandom_range(1, 6));
      else if (r < 78) sz = '0;
      else if (r < 90) sz = SIZE_W'(acr_pkg::CAPACITY);
      else sz = SIZE_W'($urandom_range(7, 31));
      eff = (sz == 0) ? 1 : ((sz > acr_pkg::CAPACITY) ? acr_pkg::CAPACITY : sz);
      if ($urandom_range(1)) begin
        plan_write(acr_pkg::REG_POLICY, DATA_W'($urandom_range(31)));
        plan_write(acr_pkg::REG_SIZE, sz);
      end else begin
        plan_write(acr_pkg::REG_SIZE, sz);
        plan_write(acr_pkg::REG_POLICY, DATA_W'($urandom_range(31)));
      end
      // a key pool a little larger than the cache gives hits and evictions
      pool.delete();
      n = eff + $urandom_range(1, 4);
      for (int i = 0; i < n; i++) pool.push_back($urandom);
      n = $urandom_range(20, 45);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 85) plan_access(pool[$urandom_range(pool.size() - 1)]);
        else plan_access($urandom);
        if ($urandom_range(39) == 0) plan_drain();
      end
      random_cnt += n;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (!(access_plan.size() == 0 && !presenting && items_sent == results_seen)) begin
      @(negedge clk);
    end
    repeat (40) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $display("%0t: %0d expected results never came", $time, expected_outcomes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
